// File: rtl/core/lkvc_pkg.sv
// Shared constants, types and command/status structs for the LRU key/value cache.
// No dependencies; every other file of the block imports this package.
package lkvc_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W   = IDX_W;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int CAP_W    = 5;
  localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int APB_W    = 32;
  localparam int PADDR_W  = 3;

  // capacity_in_use after reset: 16, held to the table size
  localparam int CAP_RESET_INT = (CAPACITY < 16) ? CAPACITY : 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_RESET_INT);

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } reg_idx_t;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_t;

  typedef struct packed {
    logic capture;   // latch the accepted request
    logic commit;    // update the table and load the result register
    logic cfg_load;  // write capacity_in_use
  } dp_cmd_t;

  typedef struct packed {
    logic table_empty;
  } dp_stat_t;

endpackage

// File: rtl/core/lkvc_ctrl.sv
// Controller state machine of the LRU key/value cache: handshakes and commands.
// Depends on lkvc_pkg.
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_wr,
  input  lkvc_pkg::dp_stat_t stat,
  output lkvc_pkg::dp_cmd_t  cmd
);
  import lkvc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    // capacity only changes while the table is empty
    cmd.cfg_load  = cfg_wr && stat.table_empty;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/lkvc_datapath.sv
// Datapath of the LRU key/value cache: entry table, recency ranks, capacity
// register and result register. Depends on lkvc_pkg.
module lkvc_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lkvc_pkg::dp_cmd_t                 cmd,
  output lkvc_pkg::dp_stat_t                stat,
  input  logic                              in_mode,
  input  logic signed [lkvc_pkg::DATA_W-1:0] in_key,
  input  logic signed [lkvc_pkg::DATA_W-1:0] in_value,
  input  logic [lkvc_pkg::CAP_W-1:0]         cfg_wdata,
  output logic [lkvc_pkg::CAP_W-1:0]         cap_value,
  output logic                              out_found,
  output logic signed [lkvc_pkg::DATA_W-1:0] out_read_value
);
  import lkvc_pkg::*;

  logic [DATA_W-1:0] key_r  [CAPACITY];
  logic [DATA_W-1:0] val_r  [CAPACITY];
  logic [RANK_W-1:0] rank_r [CAPACITY];
  logic [RANK_W-1:0] rank_nxt [CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;

  logic              mode_r;
  logic [DATA_W-1:0] req_key_r, req_val_r;
  logic              found_r;
  logic [DATA_W-1:0] rdval_r;

  logic [CAPACITY-1:0] hit_vec, evict_vec, free_vec, ins_vec;
  logic                hit, full, is_put;
  logic [DATA_W-1:0]   hit_val;
  logic [RANK_W-1:0]   hit_rank;
  logic [CNT_W-1:0]    lru_rank;

  // parallel lookup; keys of valid entries are unique, so the hit is one-hot
  always_comb begin
    hit_val  = '0;
    hit_rank = '0;
    lru_rank = used_r - CNT_W'(1);
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i]   = valid_r[i] && (key_r[i] == req_key_r);
      evict_vec[i] = valid_r[i] && (CNT_W'(rank_r[i]) == lru_rank);
      hit_val      = hit_val  | (val_r[i]  & {DATA_W{hit_vec[i]}});
      hit_rank     = hit_rank | (rank_r[i] & {RANK_W{hit_vec[i]}});
    end
    hit      = |hit_vec;
    full     = CMP_W'(used_r) >= CMP_W'(cap_r);
    // lowest invalid entry
    free_vec = ~valid_r & (valid_r + CAPACITY'(1));
    ins_vec  = full ? evict_vec : free_vec;
    is_put   = (mode_t'(mode_r) == MODE_PUT);
  end

  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    for (int i = 0; i < CAPACITY; i++) begin
      rank_nxt[i] = rank_r[i];
      if (hit) begin
        if (hit_vec[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end else if (is_put) begin
        if (ins_vec[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
    if (!hit && is_put) begin
      valid_nxt = valid_r | ins_vec;
      if (!full) begin
        used_nxt = used_r + CNT_W'(1);
      end
    end
  end

  // clamp the written capacity to 1..CAPACITY
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_nxt = CAP_W'(1);
    end else if (int'(cfg_wdata) > CAPACITY) begin
      cap_nxt = CAP_W'(CAPACITY);
    end else begin
      cap_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
      cap_r   <= CAP_RESET;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        valid_r <= valid_nxt;
        used_r  <= used_nxt;
        for (int i = 0; i < CAPACITY; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
      if (cmd.cfg_load) begin
        cap_r <= cap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r    <= in_mode;
      req_key_r <= in_key;
      req_val_r <= in_value;
    end
    if (cmd.commit) begin
      found_r <= hit;
      if (is_put) begin
        rdval_r <= PUT_VALUE;
      end else if (hit) begin
        rdval_r <= hit_val;
      end else begin
        rdval_r <= MISS_VALUE;
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (is_put && (hit ? hit_vec[i] : ins_vec[i])) begin
          val_r[i] <= req_val_r;
        end
        if (is_put && !hit && ins_vec[i]) begin
          key_r[i] <= req_key_r;
        end
      end
    end
  end

  assign stat.table_empty = (used_r == '0);
  assign cap_value        = cap_r;
  assign out_found        = found_r;
  assign out_read_value   = rdval_r;

endmodule

// File: rtl/core/lru_key_value_cache_top.sv
// Top level of the LRU key/value cache: controller, datapath, APB register decode.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per transfer; in_mode 0 is a
//   get of in_key, 1 is a put of in_key/in_value.
//   Result channel (out_valid/out_ready): one result per request, in order.
//   out_found tells whether the key was present before the request;
//   out_read_value carries the stored value on a get hit, -1 on a get miss
//   and 0 on any put.
//   Register port (APB style, pready tied high): capacity_in_use at byte
//   address 0, range 1..16 from pwdata[4:0] (0 reads back as 1, 17..31 as 16). A write
//   lands only while the table is empty; otherwise it is dropped.
// Timing:
//   A request is captured into the request register, then looked up and
//   committed to the table and result register, which raises out_valid.
//   The block takes no new request until the last one has been committed.
//   The lookup compares all 16 entries in parallel and updates every recency
//   rank in the same cycle.
// Reset (rst_n low, synchronous): table empty, all ranks cleared, capacity 16.
// Stall: while out_ready is low the result register holds; one more request
//   may be captured, and it waits in the commit stage until the result moves.
module lru_key_value_cache_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_mode,
  input  logic signed [lkvc_pkg::DATA_W-1:0] in_key,
  input  logic signed [lkvc_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic signed [lkvc_pkg::DATA_W-1:0] out_read_value,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lkvc_pkg::PADDR_W-1:0]       paddr,
  input  logic [lkvc_pkg::APB_W-1:0]         pwdata,
  output logic [lkvc_pkg::APB_W-1:0]         prdata,
  output logic                               pready
);
  import lkvc_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             cap_sel;
  logic             cfg_wr;
  logic [CAP_W-1:0] cap_value;

  // decode: word address selects the register, byte offset ignored
  assign cap_sel = (reg_idx_t'(paddr[PADDR_W-1]) == REG_CAPACITY);
  assign cfg_wr  = psel && penable && pwrite && cap_sel;
  assign pready  = 1'b1;
  assign prdata  = cap_sel ? APB_W'(cap_value) : '0;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_wr    (cfg_wr),
    .stat      (stat),
    .cmd       (cmd)
  );

  lkvc_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_value       (in_value),
    .cfg_wdata      (pwdata[CAP_W-1:0]),
    .cap_value      (cap_value),
    .out_found      (out_found),
    .out_read_value (out_read_value)
  );

endmodule

// File: rtl/core/lkvc_checker.sv
// Port-level checks for the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_top.
module lkvc_port_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_found,
  input logic signed [lkvc_pkg::DATA_W-1:0] out_read_value,
  input logic                               psel,
  input logic                               pwrite,
  input logic [lkvc_pkg::PADDR_W-1:0]       paddr,
  input logic [lkvc_pkg::APB_W-1:0]         prdata,
  input logic                               pready
);
  import lkvc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_read_value))
    else $error("result changed while stalled");

  // a miss reports -1 on get or 0 on put
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_read_value == MISS_VALUE) || (out_read_value == PUT_VALUE))
    else $error("miss result carries a stored value");

  // one request in work at a time: no transfer in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in work");

  // nothing is shown right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // capacity reads back within 1..CAPACITY
  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    psel && !pwrite && (reg_idx_t'(paddr[PADDR_W-1]) == REG_CAPACITY) && pready |->
      (prdata != '0) && (int'(prdata) <= CAPACITY))
    else $error("capacity out of range");

endmodule

bind lru_key_value_cache_top lkvc_port_checker u_lkvc_port_checker (.*);

// File: tb/lkvc_checker.sv
// Result checker for the LRU key/value cache: watches the request, result and register
// ports, predicts every result and compares it. Depends on lkvc_pkg.
`timescale 1ns / 100ps

module lkvc_checker
  import lkvc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_mode,
  input  logic [DATA_W-1:0]        in_key,
  input  logic [DATA_W-1:0]        in_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_found,
  input  logic [DATA_W-1:0]        out_read_value,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [APB_W-1:0]         pwdata,
  input  logic [APB_W-1:0]         prdata,
  input  logic                     pready,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_value;
  } cache_result_t;

  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * REG_CAPACITY);

  logic [DATA_W-1:0] slot_key   [CAPACITY];
  logic [DATA_W-1:0] slot_value [CAPACITY];
  logic              slot_valid [CAPACITY];
  int unsigned       slot_rank  [CAPACITY];
  int unsigned       used_count;
  int unsigned       cap_limit;
  cache_result_t     expected_results [$];
  int                failures = 0;

  function automatic void clear_cache();
    for (int i = 0; i < CAPACITY; i++) begin
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_valid[i] = 1'b0;
      slot_rank[i]  = 0;
    end
    used_count = 0;
    cap_limit  = CAP_RESET;
  endfunction

  function automatic int unsigned clamp_capacity(logic [CAP_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > CAPACITY) return CAPACITY;
    return raw;
  endfunction

  function automatic int find_slot(logic [DATA_W-1:0] key);
    for (int i = 0; i < CAPACITY; i++)
      if (slot_valid[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  // Move one entry to the front; entries that were more recent age by one.
  function automatic void make_most_recent(int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < CAPACITY; i++)
      if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic cache_result_t apply_request(mode_t mode, logic [DATA_W-1:0] key,
                                                  logic [DATA_W-1:0] value);
    int            hit;
    int            victim;
    cache_result_t res;
    hit       = find_slot(key);
    victim    = -1;
    res.found = (hit >= 0);
    if (mode == MODE_GET) begin
      res.read_value = MISS_VALUE;
      if (hit >= 0) begin
        res.read_value = slot_value[hit];
        make_most_recent(hit);
      end
      return res;
    end
    res.read_value = PUT_VALUE;
    if (hit >= 0) begin
      slot_value[hit] = value;
      make_most_recent(hit);
      return res;
    end
    // Full: drop the least recent entry (highest rank, lowest index on a tie).
    if (used_count >= cap_limit) begin
      for (int i = 0; i < CAPACITY; i++)
        if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
      if (victim >= 0) begin
        slot_valid[victim] = 1'b0;
        used_count--;
      end
    end
    for (int i = 0; i < CAPACITY; i++)
      if (victim < 0 && !slot_valid[i]) victim = i;
    if (victim < 0) return res;
    for (int i = 0; i < CAPACITY; i++)
      if (slot_valid[i]) slot_rank[i]++;
    slot_key[victim]   = key;
    slot_value[victim] = value;
    slot_valid[victim] = 1'b1;
    slot_rank[victim]  = 0;
    used_count++;
    return res;
  endfunction

  task automatic note_failure(input string msg);
    if (failures < 10) $display("[%0t] lkvc_checker: %s", $time, msg);
    failures++;
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst_n) begin
      clear_cache();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result found=%0b value=%h with no request outstanding",
                                 out_found, out_read_value));
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found || out_read_value !== want.read_value)
            note_failure($sformatf("result mismatch: expected found=%0b value=%h, got found=%0b value=%h",
                                   want.found, want.read_value, out_found, out_read_value));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_request(mode_t'(in_mode), in_key, in_value));
      if (psel && penable && pready) begin
        if (pwrite) begin
          // Capacity changes land only while the table is empty.
          if (paddr == CAP_ADDR && used_count == 0)
            cap_limit = clamp_capacity(pwdata[CAP_W-1:0]);
        end else if (paddr == CAP_ADDR && prdata !== APB_W'(cap_limit)) begin
          note_failure($sformatf("capacity readback: expected %0d, got %0d", cap_limit, prdata));
        end
      end
    end
    fail_count <= failures;
    pending    <= expected_results.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the LRU key/value cache testbench: clock, reset, request and register stimulus,
// final verdict. Depends on lkvc_pkg, lru_key_value_cache_top and lkvc_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 460;
  localparam int POOL_SIZE   = 24;
  localparam int IDLE_PCT    = 15;
  localparam int TAIL_CYCLES = 8;

  // Register map: capacity at index 0; index 1 is unused and must ignore writes.
  localparam logic [lkvc_pkg::PADDR_W-1:0] CAP_ADDR =
    lkvc_pkg::PADDR_W'(4 * lkvc_pkg::REG_CAPACITY);
  localparam logic [lkvc_pkg::PADDR_W-1:0] SPARE_ADDR =
    lkvc_pkg::PADDR_W'(4 * (lkvc_pkg::REG_CAPACITY + 1));

  logic                                clk            = 1'b0;
  logic                                rst_n          = 1'b0;
  logic                                in_valid       = 1'b0;
  logic                                in_ready;
  logic                                in_mode        = lkvc_pkg::MODE_GET;
  logic signed [lkvc_pkg::DATA_W-1:0]  in_key         = '0;
  logic signed [lkvc_pkg::DATA_W-1:0]  in_value       = '0;
  logic                                out_valid;
  logic                                out_ready      = 1'b0;
  logic                                out_found;
  logic signed [lkvc_pkg::DATA_W-1:0]  out_read_value;
  logic                                psel           = 1'b0;
  logic                                penable        = 1'b0;
  logic                                pwrite         = 1'b0;
  logic [lkvc_pkg::PADDR_W-1:0]        paddr          = '0;
  logic [lkvc_pkg::APB_W-1:0]          pwdata         = '0;
  logic [lkvc_pkg::APB_W-1:0]          prdata;
  logic                                pready;

  // Set during the stretch in which neither side idles.
  logic                                steady         = 1'b0;
  logic [lkvc_pkg::DATA_W-1:0]         key_pool [POOL_SIZE];
  int                                  fail_count;
  int                                  pending;

  always #4 clk = ~clk;

  lru_key_value_cache_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  lkvc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Result side: stall in about one cycle of seven, never during the steady stretch.
  always @(posedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Present one request and hold it until the transfer. Idle gaps come first so that
  // valid is never lowered and raised again at the same edge.
  task automatic send_request(input lkvc_pkg::mode_t mode,
                              input logic [lkvc_pkg::DATA_W-1:0] key,
                              input logic [lkvc_pkg::DATA_W-1:0] value);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every outstanding result has been taken. The
  // first edge lets the checker count the last transfer before pending is read.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Setup phase, access phase, then an idle phase so psel never toggles within an edge.
  task automatic apb_write(input logic [lkvc_pkg::PADDR_W-1:0] addr,
                           input logic [lkvc_pkg::APB_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // The checker compares prdata at the access edge.
  task automatic apb_read(input logic [lkvc_pkg::PADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly reuse a pool a little larger than the capacity, so hits, updates and
  // evictions all happen; now and then take a fresh key with every bit random.
  function automatic logic [lkvc_pkg::DATA_W-1:0] pick_key(input int span);
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, span - 1)];
    return $urandom();
  endfunction

  initial begin
    int cap_choice;
    int span;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;

    // Pick the capacity for this run: often one of the extremes.
    case ($urandom_range(0, 3))
      0:       cap_choice = 1;
      1:       cap_choice = lkvc_pkg::CAPACITY;
      default: cap_choice = $urandom_range(2, lkvc_pkg::CAPACITY - 1);
    endcase
    span = cap_choice + 4;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Table is empty: check reset capacity, then clamp a zero and an oversize write,
    // and poke the unused register index.
    apb_read(CAP_ADDR);
    apb_write(CAP_ADDR, '0);
    apb_read(CAP_ADDR);
    apb_write(CAP_ADDR, ($urandom() & 32'hFFFF_FFE0) | 32'h0000_001F);
    apb_read(CAP_ADDR);
    apb_write(SPARE_ADDR, $urandom());
    apb_read(CAP_ADDR);

    // Gets on an empty table miss and insert nothing, so the capacity stays writable.
    send_request(lkvc_pkg::MODE_GET, 32'h8000_0000, $urandom());
    send_request(lkvc_pkg::MODE_GET, 32'h7FFF_FFFF, $urandom());
    send_request(lkvc_pkg::MODE_GET, 32'h0000_0000, $urandom());
    send_request(lkvc_pkg::MODE_GET, 32'hFFFF_FFFF, $urandom());
    drain_results();
    apb_write(CAP_ADDR, ($urandom() & 32'hFFFF_FFE0) | 32'(cap_choice));
    apb_read(CAP_ADDR);

    // Insert the extreme keys with extreme values, then read them back.
    send_request(lkvc_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lkvc_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lkvc_pkg::MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lkvc_pkg::MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(lkvc_pkg::MODE_GET, 32'h7FFF_FFFF, '0);
    send_request(lkvc_pkg::MODE_GET, 32'h0000_0000, $urandom());
    send_request(lkvc_pkg::MODE_GET, 32'hFFFF_FFFF, $urandom());
    // Update in place, then read the new value.
    send_request(lkvc_pkg::MODE_PUT, 32'h0000_0000, 32'h1234_5678);
    send_request(lkvc_pkg::MODE_GET, 32'h0000_0000, $urandom());
    // Evict and reuse slots if the capacity is under ten, then look for an evicted key.
    for (int i = 4; i < 10; i++) send_request(lkvc_pkg::MODE_PUT, key_pool[i], $urandom());
    send_request(lkvc_pkg::MODE_GET, 32'h8000_0000, $urandom());
    send_request(lkvc_pkg::MODE_GET, key_pool[4], $urandom());
    drain_results();

    // Random phases. The second runs with no idling on either side; between phases
    // wait for every result, then write registers, which must be dropped now.
    for (int p = 0; p < PHASES; p++) begin
      steady <= (p == 1);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_request($urandom_range(0, 1) ? lkvc_pkg::MODE_PUT : lkvc_pkg::MODE_GET,
                     pick_key(span), $urandom());
      drain_results();
      steady <= 1'b0;
      if (p < PHASES - 1) begin
        apb_write(CAP_ADDR, $urandom());
        apb_read(CAP_ADDR);
        apb_write(SPARE_ADDR, $urandom());
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
